// ===== rtl/psb_pkg.sv =====
// Shared types and constants for the pseudocost branch selector.
// No dependencies; used by psb_div, the top level and the testbench.
package psb_pkg;

	localparam int MaxVars = 1024;
	localparam int IdxW    = $clog2(MaxVars);
	localparam int SizeW   = 11;
	localparam int ScanW   = 11;
	localparam int DivW    = 64;
	localparam int DvsW    = 32;

	typedef enum logic [1:0] {
		CMD_UP   = 2'd0,
		CMD_DOWN = 2'd1,
		CMD_CAND = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SMALL    = 2'd1,
		ST_BAD_IDX  = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	localparam logic [1:0] CfgNumVars = 2'd0;
	localparam logic [1:0] CfgTol     = 2'd1;
	localparam logic [1:0] CfgDefault = 2'd2;

	// One memory word: up and down statistics of a variable
	typedef struct packed {
		logic signed [47:0] up_sum;
		logic        [15:0] up_cnt;
		logic signed [47:0] dn_sum;
		logic        [15:0] dn_cnt;
	} pc_entry_t;

endpackage

// ===== rtl/psb_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on psb_pkg for widths.
module psb_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             neg,
	input  logic [psb_pkg::DivW-1:0]         dividend,
	input  logic [psb_pkg::DvsW-1:0]         divisor,
	output logic                             done,
	output logic signed [psb_pkg::DivW-1:0]  quotient
);

	localparam int CntW = $clog2(psb_pkg::DivW);

	logic                        busy_q;
	logic                        done_q;
	logic [CntW-1:0]             cnt_q;
	logic [psb_pkg::DvsW-1:0]    rem_q;
	logic [psb_pkg::DivW-1:0]    shr_q;
	logic [psb_pkg::DvsW-1:0]    dvs_q;
	logic                        neg_q;
	logic [psb_pkg::DvsW:0]      trial;
	logic [psb_pkg::DvsW:0]      diff;
	logic                        ge;

	// Trial subtract of the next dividend bit
	assign trial = {rem_q, shr_q[psb_pkg::DivW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	// Control: count the steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {CntW{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			shr_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			shr_q <= {shr_q[psb_pkg::DivW-2:0], ge};
			rem_q <= ge ? diff[psb_pkg::DvsW-1:0] : trial[psb_pkg::DvsW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(shr_q) : $signed(shr_q);

endmodule

// ===== rtl/pseudocost_branch_selector_top.sv =====
// Top level of the pseudocost branch selector: statistics memory, scan control.
// Depends on psb_pkg and psb_div.
//
//  channel   direction  handshake              beat
//  in        sink       in_valid / in_stall    command, var_index, delta_objective,
//                                              frac_distance, candidate_value, last_candidate
//  out       source     out_valid / out_stall  status, found, best_index, best_score
//  cfg       sink       cfg_we                 cfg_index, cfg_data
//
// A record waits in S_R_DIV on the 64-step serial divider.
// A scored candidate runs up to two serial divisions, one for each average.
// An unscored candidate goes through S_C_END; a rejected record goes straight to S_OUT.
// After reset a clearing pass zeroes all 1024 memory words; in_stall is high meanwhile.
// One item is in work at a time; a new beat is taken while a result waits under out_stall.
module pseudocost_branch_selector_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          command,
	input  logic [9:0]          var_index,
	input  logic signed [31:0]  delta_objective,
	input  logic [16:0]         frac_distance,
	input  logic signed [31:0]  candidate_value,
	input  logic                last_candidate,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic                found,
	output logic [9:0]          best_index,
	output logic signed [31:0]  best_score
);

	localparam int IdxW  = psb_pkg::IdxW;
	localparam int SizeW = psb_pkg::SizeW;
	localparam int ScanW = psb_pkg::ScanW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_R_RD, S_R_DIV, S_R_UPD, S_C_RD, S_C_UPS, S_C_UPW,
		S_C_DNS, S_C_DNW, S_C_CMP, S_C_END, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [SizeW-1:0]    num_vars_q;
	logic [15:0]         tol_q;
	logic signed [31:0]  default_q;

	// Item registers
	psb_pkg::cmd_t       cmd_q;
	logic [IdxW-1:0]     idx_q;
	logic signed [31:0]  delta_q;
	logic [16:0]         dist_q;
	logic                last_q;
	logic [ScanW-1:0]    pos_q;

	// Scan and statistics state
	logic [ScanW-1:0]    scan_q;
	logic signed [31:0]  run_score_q;
	logic [IdxW-1:0]     run_idx_q;
	logic                run_found_q;
	logic signed [31:0]  pu_q;
	logic signed [31:0]  pd_q;
	logic signed [63:0]  gup_sum_q;
	logic [31:0]         gup_cnt_q;
	logic signed [63:0]  gdn_sum_q;
	logic [31:0]         gdn_cnt_q;
	logic [IdxW-1:0]     clr_q;

	// Result registers
	psb_pkg::status_t    res_status_q;
	logic                res_found_q;
	logic [IdxW-1:0]     res_idx_q;
	logic signed [31:0]  res_score_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic                found_q;
	logic [IdxW-1:0]     best_index_q;
	logic signed [31:0]  best_score_q;
	logic                out_load;

	// Memory
	psb_pkg::pc_entry_t  mem [psb_pkg::MaxVars];
	psb_pkg::pc_entry_t  rd_q;
	psb_pkg::pc_entry_t  wr_data;
	logic                mem_we;
	logic [IdxW-1:0]     mem_addr;

	// Divider hookup
	logic                    div_start;
	logic                    div_neg;
	logic [63:0]             div_dividend;
	logic [31:0]             div_divisor;
	logic                    div_done;
	logic signed [63:0]      div_quot;

	logic [SizeW-1:0]    eff_n;
	logic                accept;
	logic [15:0]         in_frac;
	logic [16:0]         up_dist;
	logic                eligible;
	logic [32:0]         dmag;
	logic                dn_sel;
	logic signed [47:0]  v_sum;
	logic [15:0]         v_cnt;
	logic signed [63:0]  g_sum;
	logic [31:0]         g_cnt;
	logic signed [63:0]  num64;
	logic [63:0]         nmag;
	logic                need_div;
	logic signed [31:0]  p_sat;
	logic signed [31:0]  score;
	logic [ScanW:0]      pos_next;

	assign eff_n   = (num_vars_q > SizeW'(psb_pkg::MaxVars)) ? SizeW'(psb_pkg::MaxVars)
	                                                          : num_vars_q;
	assign accept  = (state_q == S_IDLE) && in_valid;
	assign in_stall = (state_q != S_IDLE);

	// Candidate eligibility: fractional in both directions
	assign in_frac  = candidate_value[15:0];
	assign up_dist  = (in_frac == 16'd0) ? 17'd0 : 17'h10000 - {1'b0, in_frac};
	assign eligible = ({1'b0, in_frac} > {1'b0, tol_q}) && (up_dist > {1'b0, tol_q});

	// Record ratio operands
	assign dmag = delta_q[31] ? 33'(-{delta_q[31], delta_q}) : {1'b0, delta_q};

	// Average operands: own statistics, else global, else default
	assign dn_sel   = (state_q == S_C_DNS);
	assign v_sum    = dn_sel ? rd_q.dn_sum : rd_q.up_sum;
	assign v_cnt    = dn_sel ? rd_q.dn_cnt : rd_q.up_cnt;
	assign g_sum    = dn_sel ? gdn_sum_q : gup_sum_q;
	assign g_cnt    = dn_sel ? gdn_cnt_q : gup_cnt_q;
	assign num64    = (v_cnt != 16'd0) ? 64'(v_sum) : g_sum;
	assign nmag     = num64[63] ? 64'(-num64) : 64'(num64);
	assign need_div = (v_cnt != 16'd0) || (g_cnt != 32'd0);

	always_comb begin
		if (state_q == S_R_RD) begin
			div_start    = 1'b1;
			div_neg      = delta_q[31];
			div_dividend = {15'd0, dmag, 16'd0};
			div_divisor  = {15'd0, dist_q};
		end else begin
			div_start    = ((state_q == S_C_UPS) || (state_q == S_C_DNS)) && need_div;
			div_neg      = num64[63];
			div_dividend = nmag;
			div_divisor  = (v_cnt != 16'd0) ? {16'd0, v_cnt} : g_cnt;
		end
	end

	psb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.neg      (div_neg),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Saturate the observation ratio to Q16.16
	always_comb begin
		if (div_quot > 64'sd2147483647)
			p_sat = 32'sh7FFFFFFF;
		else if (div_quot < -64'sd2147483648)
			p_sat = 32'sh80000000;
		else
			p_sat = div_quot[31:0];
	end

	assign score    = (pu_q < pd_q) ? pu_q : pd_q;
	assign pos_next = {1'b0, pos_q} + 1'b1;

	// Load the output register once it is free
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Entry write-back: zeros while clearing, else the updated direction
	always_comb begin
		wr_data = rd_q;
		if (state_q == S_CLEAR) begin
			wr_data = '0;
		end else if (cmd_q == psb_pkg::CMD_UP) begin
			if (rd_q.up_cnt != 16'hFFFF) begin
				wr_data.up_sum = rd_q.up_sum + 48'(p_sat);
				wr_data.up_cnt = rd_q.up_cnt + 1'b1;
			end
		end else begin
			if (rd_q.dn_cnt != 16'hFFFF) begin
				wr_data.dn_sum = rd_q.dn_sum + 48'(p_sat);
				wr_data.dn_cnt = rd_q.dn_cnt + 1'b1;
			end
		end
	end

	// Hold the candidate's address until both averages have been started
	assign mem_we   = (state_q == S_CLEAR) || (state_q == S_R_UPD);
	always_comb begin
		case (state_q)
			S_CLEAR: mem_addr = clr_q;
			S_C_RD, S_C_UPS, S_C_UPW, S_C_DNS: mem_addr = pos_q[IdxW-1:0];
			default: mem_addr = idx_q;
		endcase
	end

	// Statistics memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= wr_data;
		rd_q <= mem[mem_addr];
	end

	// Item payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= var_index;
			delta_q <= delta_objective;
			dist_q  <= frac_distance;
			last_q  <= last_candidate;
			pos_q   <= scan_q;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= SizeW'(psb_pkg::MaxVars);
			tol_q      <= 16'd1;
			default_q  <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				psb_pkg::CfgNumVars: num_vars_q <= cfg_data[SizeW-1:0];
				psb_pkg::CfgTol:     tol_q      <= cfg_data[15:0];
				psb_pkg::CfgDefault: default_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: state, statistics, scan and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			cmd_q        <= psb_pkg::CMD_NONE;
			scan_q       <= '0;
			run_score_q  <= 32'sh80000000;
			run_idx_q    <= '0;
			run_found_q  <= 1'b0;
			gup_sum_q    <= '0;
			gup_cnt_q    <= '0;
			gdn_sum_q    <= '0;
			gdn_cnt_q    <= '0;
			pu_q         <= '0;
			pd_q         <= '0;
			res_status_q <= psb_pkg::ST_OK;
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
			res_score_q  <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= '0;
			found_q      <= 1'b0;
			best_index_q <= '0;
			best_score_q <= '0;
		end else begin
			// load a new beat, else drop a delivered one
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {IdxW{1'b1}})
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= psb_pkg::cmd_t'(command);
						res_found_q  <= 1'b0;
						res_idx_q    <= '0;
						res_score_q  <= '0;
						case (psb_pkg::cmd_t'(command))
							psb_pkg::CMD_UP, psb_pkg::CMD_DOWN: begin
								if ({1'b0, var_index} >= eff_n) begin
									res_status_q <= psb_pkg::ST_BAD_IDX;
									state_q      <= S_OUT;
								end else if (frac_distance <= {1'b0, tol_q}) begin
									res_status_q <= psb_pkg::ST_SMALL;
									state_q      <= S_OUT;
								end else begin
									res_status_q <= psb_pkg::ST_OK;
									state_q      <= S_R_RD;
								end
							end
							psb_pkg::CMD_CAND: begin
								res_status_q <= psb_pkg::ST_OK;
								if ((scan_q < eff_n) && eligible)
									state_q <= S_C_RD;
								else
									state_q <= S_C_END;
							end
							default: ;
						endcase
					end
				end
				S_R_RD: state_q <= S_R_DIV;
				S_R_DIV: begin
					if (div_done)
						state_q <= S_R_UPD;
				end
				S_R_UPD: begin
					// update the global statistics of the chosen direction
					if (cmd_q == psb_pkg::CMD_UP) begin
						if (gup_cnt_q != 32'hFFFFFFFF) begin
							gup_sum_q <= gup_sum_q + 64'(p_sat);
							gup_cnt_q <= gup_cnt_q + 1'b1;
						end
					end else begin
						if (gdn_cnt_q != 32'hFFFFFFFF) begin
							gdn_sum_q <= gdn_sum_q + 64'(p_sat);
							gdn_cnt_q <= gdn_cnt_q + 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_C_RD: state_q <= S_C_UPS;
				S_C_UPS: begin
					if (need_div) begin
						state_q <= S_C_UPW;
					end else begin
						pu_q    <= default_q;
						state_q <= S_C_DNS;
					end
				end
				S_C_UPW: begin
					if (div_done) begin
						pu_q    <= div_quot[31:0];
						state_q <= S_C_DNS;
					end
				end
				S_C_DNS: begin
					if (need_div) begin
						state_q <= S_C_DNW;
					end else begin
						pd_q    <= default_q;
						state_q <= S_C_CMP;
					end
				end
				S_C_DNW: begin
					if (div_done) begin
						pd_q    <= div_quot[31:0];
						state_q <= S_C_CMP;
					end
				end
				S_C_CMP: begin
					// strictly greater wins, first eligible always wins
					if (!run_found_q || (score > run_score_q)) begin
						run_found_q <= 1'b1;
						run_score_q <= score;
						run_idx_q   <= pos_q[IdxW-1:0];
					end
					state_q <= S_C_END;
				end
				S_C_END: begin
					if (last_q) begin
						if (pos_next != {1'b0, eff_n}) begin
							res_status_q <= psb_pkg::ST_MISMATCH;
						end else if (run_found_q) begin
							res_found_q <= 1'b1;
							res_idx_q   <= run_idx_q;
							res_score_q <= run_score_q;
						end
						scan_q      <= '0;
						run_score_q <= 32'sh80000000;
						run_idx_q   <= '0;
						run_found_q <= 1'b0;
						state_q     <= S_OUT;
					end else begin
						// advance the scan position, saturating
						if (scan_q != {ScanW{1'b1}})
							scan_q <= scan_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_load) begin
						status_q     <= res_status_q;
						found_q      <= res_found_q;
						best_index_q <= res_idx_q;
						best_score_q <= res_score_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found      = found_q;
	assign best_index = best_index_q;
	assign best_score = best_score_q;

endmodule

// ===== dv/pseudocost_branch_selector_top_tb.sv =====
// Self-checking testbench for the pseudocost branch selector top level.
// Depends on psb_pkg and the RTL; an internal predictor checks every output beat in order.
module pseudocost_branch_selector_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 4000000;
	localparam int SettleCycles = 200;

	typedef struct packed {
		psb_pkg::status_t   status;
		logic               found;
		logic [9:0]         best_index;
		logic signed [31:0] best_score;
	} pick_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	psb_pkg::cmd_t      command = psb_pkg::CMD_NONE;
	logic [9:0]         var_index = '0;
	logic signed [31:0] delta_objective = '0;
	logic [16:0]        frac_distance = '0;
	logic signed [31:0] candidate_value = '0;
	logic               last_candidate = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic               found;
	logic [9:0]         best_index;
	logic signed [31:0] best_score;

	// predictor state: configuration, statistics and scan
	int unsigned  nv_cfg = 1024;
	int unsigned  tol_cfg = 1;
	int           dflt_cfg = 65536;
	longint       up_sum [psb_pkg::MaxVars];
	int unsigned  up_cnt [psb_pkg::MaxVars];
	longint       dn_sum [psb_pkg::MaxVars];
	int unsigned  dn_cnt [psb_pkg::MaxVars];
	longint       g_up_sum, g_dn_sum;
	int unsigned  g_up_cnt, g_dn_cnt;
	int unsigned  scan_pos;
	int           run_score;
	int unsigned  run_idx;
	bit           run_found;

	pick_t        pending_picks[$];
	int           err_count = 0;
	int           cycles = 0;
	int           items_sent = 0;
	int           tx_idle_pct = 32;
	int           rx_idle_pct = 85;
	int           hold_cycles = 0;

	pseudocost_branch_selector_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .var_index(var_index), .delta_objective(delta_objective),
		.frac_distance(frac_distance), .candidate_value(candidate_value),
		.last_candidate(last_candidate),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found(found), .best_index(best_index), .best_score(best_score)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int unsigned eff_size();
		return (nv_cfg < psb_pkg::MaxVars) ? nv_cfg : psb_pkg::MaxVars;
	endfunction

	// average pseudocost with fallback to the global average, then the default
	function automatic int avg_cost(longint s, int unsigned c, longint gs, int unsigned gc);
		if (c > 0)
			return int'(s / longint'(c));
		if (gc > 0)
			return int'(gs / longint'(gc));
		return dflt_cfg;
	endfunction

	function automatic void clear_scan();
		scan_pos = 0;
		run_score = 32'sh8000_0000;
		run_idx = 0;
		run_found = 1'b0;
	endfunction

	// advance the predictor by one accepted beat and queue any result
	function automatic void predict_pick(psb_pkg::cmd_t c, logic [9:0] idx,
			logic signed [31:0] d, logic [16:0] fd, logic signed [31:0] cv, logic lst);
		pick_t  r;
		longint p;
		int unsigned n, pos, frac, up_dist;
		int     pu, pd, sc;
		r = '{psb_pkg::ST_OK, 1'b0, 10'd0, 32'sd0};
		n = eff_size();
		if (c == psb_pkg::CMD_UP || c == psb_pkg::CMD_DOWN) begin
			if (idx >= n)
				r.status = psb_pkg::ST_BAD_IDX;
			else if (fd <= tol_cfg)
				r.status = psb_pkg::ST_SMALL;
			else begin
				p = (longint'(d) * 65536) / longint'(fd);
				if (p > 64'sd2147483647)
					p = 64'sd2147483647;
				if (p < -64'sd2147483648)
					p = -64'sd2147483648;
				if (c == psb_pkg::CMD_UP) begin
					if (up_cnt[idx] < 16'hFFFF) begin
						up_sum[idx] += p;
						up_cnt[idx]++;
					end
					if (g_up_cnt < 32'hFFFF_FFFF) begin
						g_up_sum += p;
						g_up_cnt++;
					end
				end else begin
					if (dn_cnt[idx] < 16'hFFFF) begin
						dn_sum[idx] += p;
						dn_cnt[idx]++;
					end
					if (g_dn_cnt < 32'hFFFF_FFFF) begin
						g_dn_sum += p;
						g_dn_cnt++;
					end
				end
			end
			pending_picks.push_back(r);
		end else if (c == psb_pkg::CMD_CAND) begin
			pos = scan_pos;
			if (pos < n) begin
				frac = cv[15:0];
				up_dist = (frac == 0) ? 0 : 65536 - frac;
				if (frac > tol_cfg && up_dist > tol_cfg) begin
					pu = avg_cost(up_sum[pos], up_cnt[pos], g_up_sum, g_up_cnt);
					pd = avg_cost(dn_sum[pos], dn_cnt[pos], g_dn_sum, g_dn_cnt);
					sc = (pu < pd) ? pu : pd;
					if (!run_found || sc > run_score) begin
						run_found = 1'b1;
						run_score = sc;
						run_idx = pos;
					end
				end
			end
			if (scan_pos < 2047)
				scan_pos++;
			if (lst) begin
				if (pos + 1 != n)
					r.status = psb_pkg::ST_MISMATCH;
				else if (run_found) begin
					r.found = 1'b1;
					r.best_index = run_idx[9:0];
					r.best_score = run_score;
				end
				pending_picks.push_back(r);
				clear_scan();
			end
		end
	endfunction

	task automatic report_mismatch(string what, longint exp_v, longint got_v);
		$display("ERROR %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
		err_count++;
	endtask

	// receiver: random stall or long hold-off, check each accepted beat
	always @(posedge clk) begin
		pick_t e;
		if (out_valid && !out_stall) begin
			if (pending_picks.size() == 0)
				report_mismatch("unexpected result beat, status", -1, status);
			else begin
				e = pending_picks.pop_front();
				if (status !== e.status)
					report_mismatch("status", e.status, status);
				if (found !== e.found)
					report_mismatch("found", e.found, found);
				if (best_index !== e.best_index)
					report_mismatch("best_index", e.best_index, best_index);
				if (best_score !== e.best_score)
					report_mismatch("best_score", e.best_score, best_score);
			end
		end
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else
			out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// send one beat, idling first at random; valid stays high on return
	task automatic send_item(psb_pkg::cmd_t c, logic [9:0] idx, logic signed [31:0] d,
			logic [16:0] fd, logic signed [31:0] cv, logic lst);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		command <= c;
		var_index <= idx;
		delta_objective <= d;
		frac_distance <= fd;
		candidate_value <= cv;
		last_candidate <= lst;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		items_sent++;
		predict_pick(c, idx, d, fd, cv, lst);
	endtask

	// pause the sender until every result is in and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_picks.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		drain();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			psb_pkg::CfgNumVars: nv_cfg = val[10:0];
			psb_pkg::CfgTol:     tol_cfg = val[15:0];
			psb_pkg::CfgDefault: dflt_cfg = val;
			default: ;
		endcase
	endtask

	function automatic logic [16:0] rand_dist();
		if ($urandom_range(9) == 0)
			return 17'd65536;
		return 17'($urandom_range(65536, tol_cfg + 1));
	endfunction

	function automatic logic signed [31:0] rand_delta();
		if ($urandom_range(3) == 0)
			return $urandom;
		return 32'($signed($urandom_range(400000)) - 200000);
	endfunction

	// mostly fractional values that clear the tolerance, some anything at all
	function automatic logic signed [31:0] rand_cand();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(4) != 0 && tol_cfg < 32767)
			v[15:0] = 16'($urandom_range(65535 - tol_cfg - 1, tol_cfg + 1));
		return v;
	endfunction

	task automatic send_record(int unsigned idx_hi);
		send_item($urandom_range(1) ? psb_pkg::CMD_UP : psb_pkg::CMD_DOWN,
			10'($urandom_range(idx_hi)), rand_delta(), rand_dist(), $urandom,
			1'($urandom_range(1)));
	endtask

	// one candidate vector of cnt values, records mixed in at random
	task automatic send_stream(int unsigned cnt, bit with_records);
		for (int unsigned i = 0; i < cnt; i++) begin
			if (with_records && $urandom_range(7) == 0)
				send_record(eff_size() > 0 ? eff_size() - 1 : 0);
			send_item(psb_pkg::CMD_CAND, 10'($urandom), $urandom, 17'($urandom), rand_cand(),
				i == cnt - 1);
		end
	endtask

	task automatic test_directed();
		cfg_write(psb_pkg::CfgNumVars, 32'd4);
		cfg_write(psb_pkg::CfgTol, 32'd1);
		// empty statistics: default cost for everyone, first index wins ties
		send_stream(4, 1'b0);
		// rejected records: zero distance, at tolerance, bad index at edge and top
		send_item(psb_pkg::CMD_UP, 10'd0, 32'sd65536, 17'd0, 32'sd0, 1'b0);
		send_item(psb_pkg::CMD_DOWN, 10'd0, 32'sd65536, 17'd1, 32'sd0, 1'b0);
		send_item(psb_pkg::CMD_UP, 10'd4, 32'sd65536, 17'd65536, 32'sd0, 1'b0);
		send_item(psb_pkg::CMD_DOWN, 10'd1023, 32'sd65536, 17'd65536, 32'sd0, 1'b0);
		// extremes of delta and distance, including ratio saturation
		send_item(psb_pkg::CMD_UP, 10'd0, 32'sh7FFF_FFFF, 17'd65536, 32'sd0, 1'b0);
		send_item(psb_pkg::CMD_UP, 10'd1, 32'sh7FFF_FFFF, 17'd2, 32'sd0, 1'b0);
		send_item(psb_pkg::CMD_DOWN, 10'd2, 32'sh8000_0000, 17'd2, 32'sd0, 1'b0);
		send_item(psb_pkg::CMD_DOWN, 10'd3, -32'sd1, 17'd3, 32'sd0, 1'b0);
		// unused command is dropped
		send_item(psb_pkg::CMD_NONE, 10'd1023, -32'sd1, 17'h1FFFF, -32'sd1, 1'b1);
		// integral, at tolerance, half and near-integral values
		send_item(psb_pkg::CMD_CAND, 10'd0, 32'sd0, 17'd0, 32'sh0003_0000, 1'b0);
		send_item(psb_pkg::CMD_CAND, 10'd0, 32'sd0, 17'd0, 32'sh0000_0001, 1'b0);
		send_item(psb_pkg::CMD_CAND, 10'd0, 32'sd0, 17'd0, 32'sh8000_8000, 1'b0);
		send_item(psb_pkg::CMD_CAND, 10'd0, 32'sd0, 17'd0, 32'sh7FFF_FFFE, 1'b1);
		// short, long, and single-beat streams give a size mismatch
		send_stream(2, 1'b0);
		send_stream(6, 1'b0);
		send_stream(1, 1'b0);
		// no eligible candidate at all
		for (int i = 0; i < 4; i++)
			send_item(psb_pkg::CMD_CAND, 10'd0, 32'sd0, 17'd0, 32'sh0001_0000, i == 3);
		// a size of zero makes every stream a mismatch and every record a bad index
		cfg_write(psb_pkg::CfgNumVars, 32'd0);
		send_item(psb_pkg::CMD_UP, 10'd0, 32'sd65536, 17'd65536, 32'sd0, 1'b0);
		send_stream(1, 1'b0);
	endtask

	// most negative default: first eligible candidate must still win
	task automatic test_negative_default();
		cfg_write(psb_pkg::CfgNumVars, 32'd3);
		cfg_write(psb_pkg::CfgDefault, 32'h8000_0000);
		cfg_write(psb_pkg::CfgTol, 32'd0);
		send_stream(3, 1'b0);
	endtask

	// largest size, one full vector
	task automatic test_full_vector();
		cfg_write(psb_pkg::CfgNumVars, 32'd1024);
		cfg_write(psb_pkg::CfgDefault, 32'h7FFF_FFFF);
		send_record(1023);
		send_stream(1024, 1'b0);
	endtask

	// random phase: well-formed vectors with random content, plus noise
	task automatic test_random(int n_items, int unsigned nv, int unsigned tol,
			logic [31:0] dflt);
		int stop;
		int unsigned r;
		cfg_write(psb_pkg::CfgNumVars, nv);
		cfg_write(psb_pkg::CfgTol, tol);
		cfg_write(psb_pkg::CfgDefault, dflt);
		stop = items_sent + n_items;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (r < 60)
				send_stream(eff_size(), 1'b1);
			else if (r < 68)
				send_stream($urandom_range(eff_size() + 2, 1), 1'b0);
			else if (r < 90)
				send_record($urandom_range(15) == 0 ? 1023 : eff_size());
			else
				send_item(psb_pkg::CMD_CAND, 10'($urandom), $urandom, 17'($urandom),
					$urandom, $urandom_range(3) == 0);
		end
	endtask

	// receiver holds off long while records pile up, then the sender waits it out
	task automatic test_backpressure();
		cfg_write(psb_pkg::CfgNumVars, 32'd8);
		hold_cycles = 3000;
		for (int i = 0; i < 12; i++)
			send_record(7);
		drain();
		send_stream(8, 1'b1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);

		tx_idle_pct = 32;
		rx_idle_pct = 85;
		test_directed();
		test_negative_default();
		test_full_vector();
		test_random(150, 8, 1, 32'h0001_0000);
		test_random(60, 1, 0, 32'h8000_0000);

		tx_idle_pct = 85;
		rx_idle_pct = 32;
		test_random(60, 12, 65535, 32'h7FFF_FFFF);
		test_random(100, 5, $urandom_range(2000), $urandom);
		test_backpressure();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(100, 16, 300, $urandom);

		drain();
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clear_scan();
		for (int i = 0; i < psb_pkg::MaxVars; i++) begin
			up_sum[i] = 0;
			up_cnt[i] = 0;
			dn_sum[i] = 0;
			dn_cnt[i] = 0;
		end
		g_up_sum = 0;
		g_dn_sum = 0;
		g_up_cnt = 0;
		g_dn_cnt = 0;
	end

endmodule

// ===== files.f =====
rtl/psb_pkg.sv
rtl/psb_div.sv
rtl/pseudocost_branch_selector_top.sv
dv/pseudocost_branch_selector_top_tb.sv
